[rtl/des_pkg.sv]
// ----------------------------------------------------------------------------
// DES package
// Permutation tables, S-boxes and round helpers shared by the DES pipeline.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int ROUNDS = 16;

  typedef logic [63:0] blk_t;
  typedef logic [47:0] subkey_t;
  typedef logic [55:0] cd_t;

  typedef struct packed {
    logic  mode;
    blk_t  lr;
  } stage_t;

  localparam byte unsigned TAB_IP [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam byte unsigned TAB_FP [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam byte unsigned TAB_E [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam byte unsigned TAB_P [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam byte unsigned TAB_PC1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

  localparam byte unsigned TAB_PC2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  localparam byte unsigned TAB_ROT [ROUNDS] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam byte unsigned TAB_SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic blk_t perm_ip(input blk_t x);
    blk_t r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-TAB_IP[i]];
    return r;
  endfunction

  function automatic blk_t perm_fp(input blk_t x);
    blk_t r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-TAB_FP[i]];
    return r;
  endfunction

  function automatic cd_t perm_pc1(input blk_t x);
    cd_t r;
    for (int i = 0; i < 56; i++) r[55-i] = x[64-TAB_PC1[i]];
    return r;
  endfunction

  function automatic subkey_t perm_pc2(input cd_t x);
    subkey_t r;
    for (int i = 0; i < 48; i++) r[47-i] = x[56-TAB_PC2[i]];
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] x, input int n);
    logic [27:0] r;
    r = x;
    for (int i = 0; i < n; i++) r = {r[26:0], r[27]};
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] rh, input subkey_t k);
    logic [47:0] x;
    logic [5:0]  b;
    logic [31:0] s;
    logic [31:0] p;
    for (int i = 0; i < 48; i++) x[47-i] = rh[32-TAB_E[i]];
    x = x ^ k;
    for (int j = 0; j < 8; j++) begin
      b = x[47-6*j -: 6];
      s[31-4*j -: 4] = TAB_SBOX[j][{b[5], b[0], b[4:1]}][3:0];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
    return p;
  endfunction

endpackage

[rtl/des_keysched.sv]
// ----------------------------------------------------------------------------
// DES key schedule
// Derives the sixteen round keys from the configured key register.
// ----------------------------------------------------------------------------
module des_keysched
  import des_pkg::*;
(
  input  logic    clk,
  input  blk_t    key,
  output subkey_t subkeys [ROUNDS]
);

  cd_t     cd [ROUNDS+1];
  subkey_t sub_r [ROUNDS];

  always_comb begin
    cd[0] = perm_pc1(key);
    for (int i = 0; i < ROUNDS; i++) begin
      cd[i+1] = {rot28(cd[i][55:28], int'(TAB_ROT[i])), rot28(cd[i][27:0], int'(TAB_ROT[i]))};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ROUNDS; i++) sub_r[i] <= perm_pc2(cd[i+1]);
  end

  assign subkeys = sub_r;

endmodule

[rtl/des_round.sv]
// ----------------------------------------------------------------------------
// DES round stage
// One Feistel round with its pipeline register and valid bit.
// ----------------------------------------------------------------------------
module des_round
  import des_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    vld_in,
  input  stage_t  din,
  input  subkey_t k_enc,
  input  subkey_t k_dec,
  output logic    vld_out,
  output stage_t  dout
);

  logic    vld_r;
  stage_t  data_r;
  stage_t  data_nxt;
  subkey_t k;

  always_comb begin
    k = din.mode ? k_dec : k_enc;
    data_nxt.mode = din.mode;
    data_nxt.lr = {din.lr[31:0], din.lr[63:32] ^ feistel(din.lr[31:0], k)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign vld_out = vld_r;
  assign dout    = data_r;

endmodule

[rtl/des_block_cipher.sv]
// ----------------------------------------------------------------------------
// DES block cipher
// Fully unrolled 16-round DES pipeline, encrypt or decrypt per word.
// ----------------------------------------------------------------------------
// Accepts one 64-bit word per cycle while not stalled; the pipe is an input permutation
// register, 16 round stages and an output register, with one Feistel round per
// stage. The whole pipe holds while out_stall is high with a result waiting.
// Round keys are registered from the key register that a cfg write loads, so
// write the key only while the pipe is empty.
module des_block_cipher
  import des_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_cipher_key,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [63:0] in_data_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_block
);

  blk_t    key_r;
  subkey_t subkeys [ROUNDS];
  logic    adv;
  logic    vld [ROUNDS+1];
  stage_t  stg [ROUNDS+1];
  logic    vld0_r;
  stage_t  stg0_r;
  logic    ovld_r;
  blk_t    ores_r;
  blk_t    ip_blk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid) begin
      key_r <= cfg_cipher_key;
    end
  end

  des_keysched u_ks (.clk(clk), .key(key_r), .subkeys(subkeys));

  // hold everything while the output word is stalled
  assign adv      = !(ovld_r && out_stall);
  assign in_stall = !adv;
  assign ip_blk   = perm_ip(in_data_block);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg0_r <= '{mode: in_mode, lr: ip_blk};
    end
  end

  assign vld[0] = vld0_r;
  assign stg[0] = stg0_r;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
    des_round u_rnd (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_in(vld[g]), .din(stg[g]),
      .k_enc(subkeys[g]), .k_dec(subkeys[ROUNDS-1-g]),
      .vld_out(vld[g+1]), .dout(stg[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (adv) begin
      ovld_r <= vld[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ores_r <= perm_fp({stg[ROUNDS].lr[31:0], stg[ROUNDS].lr[63:32]});
    end
  end

  assign out_valid        = ovld_r;
  assign out_result_block = ores_r;

endmodule

[tb/sv/des_block_cipher_test.sv]
// ----------------------------------------------------------------------------
// DES block cipher testbench
// Drives plaintext and ciphertext words through the DES pipeline under several
// keys, predicts each result with a local DES model and checks it in order.
// Both sides idle at random; a long output stall fills the pipe.
// ----------------------------------------------------------------------------
module des_block_cipher_test;
  import des_pkg::*;

  localparam int LATENCY = 18;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_cipher_key;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [63:0] in_data_block;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_result_block;

  des_block_cipher i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_cipher_key   (cfg_cipher_key),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_data_block    (in_data_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block)
  );

  logic [63:0] key_reg;
  logic [63:0] expected_blocks[$];
  int          error_count;
  int          burst_left;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [47:0] round_key(input logic [63:0] key, input int round);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [55:0] cat;
    logic [47:0] k;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-TAB_PC1[i]];
    c = cd[55:28];
    d = cd[27:0];
    for (int r = 0; r <= round; r++) begin
      for (int n = 0; n < TAB_ROT[r]; n++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
    end
    cat = {c, d};
    for (int i = 0; i < 48; i++) k[47-i] = cat[56-TAB_PC2[i]];
    return k;
  endfunction

  function automatic logic [31:0] round_func(input logic [31:0] rh, input logic [47:0] k);
    logic [47:0] x;
    logic [5:0]  b;
    logic [31:0] s;
    logic [31:0] p;
    int          row;
    int          col;
    for (int i = 0; i < 48; i++) x[47-i] = rh[32-TAB_E[i]];
    x ^= k;
    for (int j = 0; j < 8; j++) begin
      b = x[47-6*j -: 6];
      row = b[5] * 2 + b[0];
      col = b[4:1];
      s[31-4*j -: 4] = TAB_SBOX[j][row*16+col][3:0];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
    return p;
  endfunction

  function automatic logic [63:0] des_compute(input logic [63:0] key, input logic dec,
                                              input logic [63:0] blk);
    logic [63:0] ip;
    logic [63:0] pre;
    logic [63:0] res;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    for (int i = 0; i < 64; i++) ip[63-i] = blk[64-TAB_IP[i]];
    l = ip[63:32];
    r = ip[31:0];
    for (int i = 0; i < 16; i++) begin
      t = l ^ round_func(r, round_key(key, dec ? 15 - i : i));
      l = r;
      r = t;
    end
    pre = {r, l};
    for (int i = 0; i < 64; i++) res[63-i] = pre[64-TAB_FP[i]];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // check each result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("unexpected word", out_result_block, 64'h0);
      end else begin
        if (out_result_block !== expected_blocks[0])
          report_mismatch("result_block", out_result_block, expected_blocks[0]);
        void'(expected_blocks.pop_front());
      end
    end
  end

  // output stall pattern, with forced long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: out_stall <= ($urandom_range(0, 1) == 1);
        1: out_stall <= 1'b0;
        default: out_stall <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_word(input logic mode, input logic [63:0] blk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_data_block <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_blocks.push_back(des_compute(key_reg, mode, blk));
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] key);
    cfg_valid      <= 1'b1;
    cfg_cipher_key <= key;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    key_reg = key;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_reset_key();
    send_word(1'b0, 64'h0);
    send_word(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    drain_pipe();
  endtask

  task automatic test_directed();
    write_key(64'h1334_5779_9BBC_DFF1);
    send_word(1'b0, 64'h0123_4567_89AB_CDEF);
    send_word(1'b1, 64'h85E8_1354_0F0A_B405);
    send_word(1'b0, 64'h0);
    send_word(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(1'b0, 64'h8000_0000_0000_0001);
    send_word(1'b1, 64'h5555_AAAA_5555_AAAA);
    drain_pipe();
    // weak and extreme keys
    write_key(64'h0101_0101_0101_0101);
    send_word(1'b0, 64'h0123_4567_89AB_CDEF);
    send_word(1'b1, 64'h0123_4567_89AB_CDEF);
    drain_pipe();
    write_key(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(1'b1, 64'h0);
    drain_pipe();
    write_key(64'h01FE_01FE_01FE_01FE);
    send_word(1'b0, 64'hA5A5_5A5A_0F0F_F0F0);
    send_word(1'b1, 64'hA5A5_5A5A_0F0F_F0F0);
    drain_pipe();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      write_key(rand64());
      repeat (120) send_word($urandom_range(0, 1), rand64());
      drain_pipe();
    end
  endtask

  task automatic test_backpressure();
    write_key(rand64());
    hold_cycles = 150;
    repeat (60) send_word($urandom_range(0, 1), rand64());
    drain_pipe();
  endtask

  task automatic test_round_trip();
    logic [63:0] p;
    write_key(rand64());
    for (int n = 0; n < 20; n++) begin
      p = rand64();
      send_word(1'b0, p);
      send_word(1'b1, des_compute(key_reg, 1'b0, p));
    end
    drain_pipe();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_cipher_key = '0;
    in_valid       = 1'b0;
    in_mode        = 1'b0;
    in_data_block  = '0;
    key_reg        = '0;
    error_count    = 0;
    burst_left     = 0;
    hold_cycles    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_key();
    test_directed();
    test_backpressure();
    test_round_trip();
    test_random();
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[des_block_cipher.f]
rtl/des_pkg.sv
rtl/des_keysched.sv
rtl/des_round.sv
rtl/des_block_cipher.sv
tb/sv/des_block_cipher_test.sv
